[hdl/stt_pkg.sv]
// Shared types, field widths and character codes for the scrolling text terminal.
package stt_pkg;

	// Geometry defaults
	localparam int COLUMNS_DEF = 40;
	localparam int ROWS_DEF    = 24;

	// Field widths of the stream words
	localparam int W_OP     = 2;
	localparam int W_CODE   = 8;
	localparam int W_COL    = 6;
	localparam int W_ROW    = 5;
	localparam int W_GLYPH  = 7;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 24;

	// Character codes and glyphs
	localparam logic [W_CODE-1:0]  CODE_CR      = 8'h0D;
	localparam logic [W_CODE-1:0]  CODE_BS      = 8'h08;
	localparam logic [W_CODE-1:0]  CODE_SPACE   = 8'h20;
	localparam logic [W_GLYPH-1:0] GLYPH_FOLD   = 7'h5F;
	localparam logic [W_GLYPH-1:0] GLYPH_BLANK  = 7'h20;
	localparam logic [W_GLYPH-1:0] GLYPH_UNDER  = 7'h5F;
	localparam logic [W_GLYPH-1:0] GLYPH_AT     = 7'h40;
	localparam logic [W_GLYPH-1:0] GLYPH_NONE   = 7'h00;

	// Operation codes
	typedef enum logic [W_OP-1:0] {
		OP_WRITE = 2'd0,
		OP_CLEAR = 2'd1,
		OP_SET   = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ROWCHK,
		ST_PLACE,
		ST_SWEEP,
		ST_WRITE,
		ST_RDMEM,
		ST_DONE
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic row_calc;
		logic sweep_wr;
		logic cell_wr;
		logic rd_en;
		logic out_load;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic needs_write;
		logic is_read;
		logic row_ready;
		logic sweep_last;
		logic out_free;
	} status_t;

endpackage

[hdl/stt_ctrl.sv]
// Controller state machine of the scrolling text terminal.
module stt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  stt_pkg::status_t st,
	output stt_pkg::cmd_t    cmd
);

	stt_pkg::state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stt_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			stt_pkg::ST_IDLE: begin
				if (s_tvalid) state_nxt = stt_pkg::ST_EXEC;
			end
			stt_pkg::ST_EXEC: begin
				if (st.needs_write || st.is_read) state_nxt = stt_pkg::ST_ROWCHK;
				else state_nxt = stt_pkg::ST_DONE;
			end
			stt_pkg::ST_ROWCHK: state_nxt = stt_pkg::ST_PLACE;
			stt_pkg::ST_PLACE: begin
				if (st.is_read) state_nxt = stt_pkg::ST_RDMEM;
				else if (st.row_ready) state_nxt = stt_pkg::ST_WRITE;
				else state_nxt = stt_pkg::ST_SWEEP;
			end
			stt_pkg::ST_SWEEP: begin
				if (st.sweep_last) state_nxt = stt_pkg::ST_WRITE;
			end
			stt_pkg::ST_WRITE: state_nxt = stt_pkg::ST_DONE;
			stt_pkg::ST_RDMEM: state_nxt = stt_pkg::ST_DONE;
			stt_pkg::ST_DONE: begin
				if (st.out_free) state_nxt = stt_pkg::ST_IDLE;
			end
			default: state_nxt = stt_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			stt_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			stt_pkg::ST_EXEC:   cmd.exec     = 1'b1;
			stt_pkg::ST_ROWCHK: cmd.row_calc = 1'b1;
			stt_pkg::ST_PLACE:  ;
			stt_pkg::ST_SWEEP:  cmd.sweep_wr = 1'b1;
			stt_pkg::ST_WRITE:  cmd.cell_wr  = 1'b1;
			stt_pkg::ST_RDMEM:  cmd.rd_en    = 1'b1;
			stt_pkg::ST_DONE:   cmd.out_load = st.out_free;
			default:            ;
		endcase
	end

endmodule

[hdl/stt_dp.sv]
// Datapath of the scrolling text terminal: cursor, top pointer, row flags, screen memory.
module stt_dp #(
	parameter int COLUMNS = stt_pkg::COLUMNS_DEF,
	parameter int ROWS    = stt_pkg::ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  stt_pkg::cmd_t               cmd,
	output stt_pkg::status_t            st,
	input  logic [stt_pkg::W_OP-1:0]    operation,
	input  logic [stt_pkg::W_CODE-1:0]  char_code,
	input  logic [stt_pkg::W_COL-1:0]   column,
	input  logic [stt_pkg::W_ROW-1:0]   row,
	input  logic                        boot_hold,
	input  logic                        m_tready,
	output logic                        m_tvalid,
	output logic [stt_pkg::W_COL-1:0]   cursor_col,
	output logic [stt_pkg::W_ROW-1:0]   cursor_row,
	output logic [stt_pkg::W_ROW-1:0]   top_row,
	output logic [stt_pkg::W_GLYPH-1:0] cell_glyph
);

	localparam int WC    = stt_pkg::W_COL;
	localparam int WR    = stt_pkg::W_ROW;
	localparam int WG    = stt_pkg::W_GLYPH;
	localparam int WCODE = stt_pkg::W_CODE;
	localparam int CW    = $clog2(COLUMNS + 1);
	localparam int CIW   = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int DEPTH = COLUMNS * ROWS;
	localparam int AW    = $clog2(DEPTH);

	// Latched item
	stt_pkg::op_t      op_q;
	logic [WCODE-1:0]  code_q;
	logic [WC-1:0]     in_col_q;
	logic [WR-1:0]     in_row_q;
	logic              hold_q;

	// Terminal state
	logic [CW-1:0]     cur_col_q;
	logic [RW-1:0]     cur_line_q;
	logic [RW-1:0]     top_q;
	logic [ROWS-1:0]   row_mat_q;
	logic [ROWS-1:0]   row_blank_q;

	// Work registers for the cell access
	logic [CIW-1:0]    tgt_col_q;
	logic [WG-1:0]     tgt_glyph_q;
	logic [RW-1:0]     prow_q;
	logic [AW-1:0]     base_q;
	logic [CIW-1:0]    sweep_cnt_q;
	logic [WG-1:0]     rd_q;

	// Output register
	logic              out_valid_q;
	logic [WC-1:0]     out_col_q;
	logic [WR-1:0]     out_row_q;
	logic [WR-1:0]     out_top_q;
	logic [WG-1:0]     out_glyph_q;

	// Screen memory
	logic [WG-1:0]     mem [DEPTH];

	// Decode of the latched item against the current cursor
	logic            wr_op, is_cr, is_bs, is_print, col_nz, wrap, adv, scroll;
	logic            rd_in_range;
	logic [WG-1:0]   folded;
	logic [RW-1:0]   line_sel;
	logic [RW:0]     row_sum;
	logic [RW-1:0]   phys_row;
	logic [AW-1:0]   sweep_addr, cell_addr;
	logic [WG-1:0]   fill_glyph, virt_glyph, read_glyph;

	always_comb begin
		wr_op    = (op_q == stt_pkg::OP_WRITE) && !hold_q;
		is_cr    = code_q == stt_pkg::CODE_CR;
		is_bs    = code_q == stt_pkg::CODE_BS;
		is_print = code_q >= stt_pkg::CODE_SPACE;
		col_nz   = cur_col_q != '0;
		wrap     = cur_col_q >= CW'(COLUMNS);
		adv      = wr_op && (is_cr || (is_print && wrap));
		scroll   = adv && (cur_line_q == RW'(ROWS - 1));
		folded   = code_q[WG-1:0];
		if (folded[WG-1]) folded = folded & stt_pkg::GLYPH_FOLD;
		rd_in_range = ({1'b0, in_col_q} < (WC + 1)'(COLUMNS)) &&
			({1'b0, in_row_q} < (WR + 1)'(ROWS));
	end

	assign st.needs_write = wr_op && (is_print || (is_bs && col_nz));
	assign st.is_read     = op_q == stt_pkg::OP_READ;
	assign st.row_ready   = row_mat_q[prow_q];
	assign st.sweep_last  = sweep_cnt_q == CIW'(COLUMNS - 1);
	assign st.out_free    = !out_valid_q || m_tready;

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= stt_pkg::op_t'(operation);
			code_q   <= char_code;
			in_col_q <= column;
			in_row_q <= row;
			hold_q   <= boot_hold;
		end
	end

	// Cursor and top pointer update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q  <= '0;
			cur_line_q <= '0;
			top_q      <= '0;
		end else if (cmd.exec) begin
			case (op_q)
				stt_pkg::OP_CLEAR: begin
					cur_col_q  <= '0;
					cur_line_q <= '0;
					top_q      <= '0;
				end
				stt_pkg::OP_SET: begin
					cur_col_q  <= ({1'b0, in_col_q} < (WC + 1)'(COLUMNS)) ? CW'(in_col_q) : '0;
					cur_line_q <= ({1'b0, in_row_q} < (WR + 1)'(ROWS)) ? RW'(in_row_q) : '0;
				end
				stt_pkg::OP_WRITE: begin
					if (adv) begin
						cur_col_q <= is_cr ? '0 : CW'(1);
						if (scroll) begin
							top_q <= (top_q == RW'(ROWS - 1)) ? '0 : top_q + 1'b1;
						end else begin
							cur_line_q <= cur_line_q + 1'b1;
						end
					end else if (wr_op && is_bs && col_nz) begin
						cur_col_q <= cur_col_q - 1'b1;
					end else if (wr_op && is_print) begin
						cur_col_q <= cur_col_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Target cell of this item
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (op_q == stt_pkg::OP_READ) tgt_col_q <= CIW'(in_col_q);
			else if (is_bs) tgt_col_q <= CIW'(cur_col_q - 1'b1);
			else if (wrap) tgt_col_q <= '0;
			else tgt_col_q <= CIW'(cur_col_q);
			tgt_glyph_q <= is_bs ? stt_pkg::GLYPH_BLANK : folded;
		end
	end

	// Row flags: a row not yet filled reads as its reset pattern or as blanks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_mat_q   <= '0;
			row_blank_q <= '0;
		end else if (cmd.exec && op_q == stt_pkg::OP_CLEAR) begin
			row_mat_q   <= '0;
			row_blank_q <= '1;
		end else if (cmd.exec && scroll) begin
			row_mat_q[top_q]   <= 1'b0;
			row_blank_q[top_q] <= 1'b1;
		end else if (cmd.sweep_wr && st.sweep_last) begin
			row_mat_q[prow_q] <= 1'b1;
		end
	end

	// Logical to physical row
	always_comb begin
		line_sel = st.is_read ? RW'(in_row_q) : cur_line_q;
		row_sum  = {1'b0, top_q} + {1'b0, line_sel};
		phys_row = (row_sum >= (RW + 1)'(ROWS)) ? RW'(row_sum - (RW + 1)'(ROWS)) : RW'(row_sum);
	end

	always_ff @(posedge clk) begin
		if (cmd.row_calc) begin
			prow_q      <= phys_row;
			base_q      <= AW'(phys_row) * AW'(COLUMNS);
			sweep_cnt_q <= '0;
		end else if (cmd.sweep_wr) begin
			sweep_cnt_q <= sweep_cnt_q + 1'b1;
		end
	end

	// Memory addressing and fill values
	always_comb begin
		sweep_addr = base_q + AW'(sweep_cnt_q);
		cell_addr  = base_q + AW'(tgt_col_q);
		if (row_blank_q[prow_q]) fill_glyph = stt_pkg::GLYPH_BLANK;
		else fill_glyph = sweep_cnt_q[0] ? stt_pkg::GLYPH_AT : stt_pkg::GLYPH_UNDER;
		if (row_blank_q[prow_q]) virt_glyph = stt_pkg::GLYPH_BLANK;
		else virt_glyph = tgt_col_q[0] ? stt_pkg::GLYPH_AT : stt_pkg::GLYPH_UNDER;
	end

	// Screen memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.sweep_wr) mem[sweep_addr] <= fill_glyph;
		else if (cmd.cell_wr) mem[cell_addr] <= tgt_glyph_q;
		if (cmd.rd_en && rd_in_range) rd_q <= mem[cell_addr];
	end

	// Glyph returned by a read
	always_comb begin
		if (!st.is_read || !rd_in_range) read_glyph = stt_pkg::GLYPH_NONE;
		else if (row_mat_q[prow_q]) read_glyph = rd_q;
		else read_glyph = virt_glyph;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_col_q   <= WC'(cur_col_q);
			out_row_q   <= WR'(cur_line_q);
			out_top_q   <= WR'(top_q);
			out_glyph_q <= read_glyph;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign cursor_col = out_col_q;
	assign cursor_row = out_row_q;
	assign top_row    = out_top_q;
	assign cell_glyph = out_glyph_q;

endmodule

[hdl/scrolling_text_terminal.sv]
// Top level of the scrolling text terminal: stream ports, controller and datapath.
//
// A COLUMNS x ROWS character terminal with a circular top-row pointer. Each
// input word carries one operation (write character, clear, set cursor, read
// cell) and yields exactly one result word with the cursor, top pointer and
// read glyph. Items are handled one at a time; a finished result sits in an
// output register, so the next word is taken while it waits. Clear, set
// cursor, carriage return, backspace at column 0, dropped writes and ignored
// codes end after the execute state; a read passes row check, place and memory
// read; a character or backspace into a row already in memory passes row check,
// place and write, and into a row untouched since reset, clear or scroll also a
// sweep before the write, as that row is first filled through the single memory
// write port one cell per cycle. An item also waits in its last cycle while the
// previous result word has not been taken. Reset, clear and scroll take effect
// at once through per-row flags, so there is no clearing pass after reset.
module scrolling_text_terminal #(
	parameter int COLUMNS = stt_pkg::COLUMNS_DEF,
	parameter int ROWS    = stt_pkg::ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// char_code[7:0], column[13:8], row[18:14], boot_hold[19], zero fill
	input  logic [stt_pkg::S_DATA_W-1:0] s_tdata,
	// operation[1:0]
	input  logic [stt_pkg::W_OP-1:0]     s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// cursor_col[5:0], cursor_row[10:6], top_row[15:11], cell_glyph[22:16], zero fill
	output logic [stt_pkg::M_DATA_W-1:0] m_tdata
);

	stt_pkg::cmd_t    cmd;
	stt_pkg::status_t st;

	logic [stt_pkg::W_COL-1:0]   cursor_col;
	logic [stt_pkg::W_ROW-1:0]   cursor_row;
	logic [stt_pkg::W_ROW-1:0]   top_row;
	logic [stt_pkg::W_GLYPH-1:0] cell_glyph;

	stt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	stt_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.operation  (s_tuser),
		.char_code  (s_tdata[7:0]),
		.column     (s_tdata[13:8]),
		.row        (s_tdata[18:14]),
		.boot_hold  (s_tdata[19]),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.cursor_col (cursor_col),
		.cursor_row (cursor_row),
		.top_row    (top_row),
		.cell_glyph (cell_glyph)
	);

	// Pack the result word
	assign m_tdata = {1'b0, cell_glyph, top_row, cursor_row, cursor_col};

endmodule

[dv/stt_checker.sv]
// Checker for the scrolling text terminal: watches both streams, predicts each result word.
`timescale 1ns / 100ps

module stt_checker
	import stt_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	// char_code[7:0], column[13:8], row[18:14], boot_hold[19], zero fill
	input  logic [S_DATA_W-1:0]  s_tdata,
	// operation[1:0]
	input  logic [W_OP-1:0]      s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	// cursor_col[5:0], cursor_row[10:6], top_row[15:11], cell_glyph[22:16], zero fill
	input  logic [M_DATA_W-1:0]  m_tdata,
	output int                   mismatch_count,
	output int                   words_pending
);

	// Result word layout, lowest field last
	typedef struct packed {
		logic [W_GLYPH-1:0] cell_glyph;
		logic [W_ROW-1:0]   top_row;
		logic [W_ROW-1:0]   cursor_row;
		logic [W_COL-1:0]   cursor_col;
	} term_result_t;

	// Shadow copy of the terminal
	logic [W_GLYPH-1:0] shadow_screen [ROWS*COLUMNS];
	int unsigned        cur_col;
	int unsigned        cur_line;
	int unsigned        top_line;

	term_result_t predicted_words [$];

	initial mismatch_count = 0;

	function automatic int unsigned cell_at(int unsigned line, int unsigned col);
		return ((top_line + line) % ROWS) * COLUMNS + col;
	endfunction

	// Power-on pattern: underscore on even columns, at-sign on odd ones
	function automatic void restore_power_on();
		for (int i = 0; i < ROWS * COLUMNS; i++)
			shadow_screen[i] = ((i % COLUMNS) & 1) ? GLYPH_AT : GLYPH_UNDER;
		cur_col  = 0;
		cur_line = 0;
		top_line = 0;
	endfunction

	// New line; past the last row the oldest row is blanked and the top moves down
	function automatic void new_line();
		cur_col = 0;
		cur_line++;
		if (cur_line >= ROWS) begin
			for (int x = 0; x < COLUMNS; x++)
				shadow_screen[top_line * COLUMNS + x] = GLYPH_BLANK;
			top_line = (top_line + 1) % ROWS;
			cur_line = ROWS - 1;
		end
	endfunction

	function automatic void put_char(logic [W_CODE-1:0] code);
		logic [W_GLYPH-1:0] glyph;
		if (code == CODE_CR) begin
			new_line();
		end else if (code == CODE_BS) begin
			if (cur_col > 0) begin
				cur_col--;
				shadow_screen[cell_at(cur_line, cur_col)] = GLYPH_BLANK;
			end
		end else if (code >= CODE_SPACE) begin
			// lower-case range folds onto upper case
			glyph = code[W_GLYPH-1:0];
			if (glyph[6])
				glyph = glyph & GLYPH_FOLD;
			if (cur_col >= COLUMNS)
				new_line();
			shadow_screen[cell_at(cur_line, cur_col)] = glyph;
			cur_col++;
		end
	endfunction

	function automatic term_result_t terminal_predict(op_t op, logic [S_DATA_W-1:0] word);
		logic [W_CODE-1:0] code;
		logic [W_COL-1:0]  col;
		logic [W_ROW-1:0]  line;
		logic              hold;
		term_result_t      res;
		code = word[7:0];
		col  = word[13:8];
		line = word[18:14];
		hold = word[19];
		res.cell_glyph = GLYPH_NONE;
		case (op)
			OP_WRITE: begin
				if (!hold)
					put_char(code);
			end
			OP_CLEAR: begin
				for (int i = 0; i < ROWS * COLUMNS; i++)
					shadow_screen[i] = GLYPH_BLANK;
				cur_col  = 0;
				cur_line = 0;
				top_line = 0;
			end
			OP_SET: begin
				cur_col  = (col < COLUMNS) ? col : 0;
				cur_line = (line < ROWS) ? line : 0;
			end
			default: begin
				if (col < COLUMNS && line < ROWS)
					res.cell_glyph = shadow_screen[cell_at(line, col)];
			end
		endcase
		res.cursor_col = W_COL'(cur_col);
		res.cursor_row = W_ROW'(cur_line);
		res.top_row    = W_ROW'(top_line);
		return res;
	endfunction

	function automatic void check_field(string name, int want_v, int got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, actual %0d", name, want_v, got_v);
			mismatch_count++;
		end
	endfunction

	// Predict on each accepted input word, compare on each accepted result word
	always @(posedge clk or negedge arst_n) begin : scoreboard
		term_result_t want;
		term_result_t got;
		if (!arst_n) begin
			restore_power_on();
			predicted_words.delete();
		end else begin
			if (s_tvalid && s_tready)
				predicted_words.insert(predicted_words.size(),
					terminal_predict(op_t'(s_tuser), s_tdata));
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(term_result_t)-1:0];
				if (predicted_words.size() == 0) begin
					$error("result word %h with no prediction waiting", m_tdata);
					mismatch_count++;
				end else begin
					want = predicted_words.pop_front();
					check_field("cursor_col", want.cursor_col, got.cursor_col);
					check_field("cursor_row", want.cursor_row, got.cursor_row);
					check_field("top_row", want.top_row, got.top_row);
					check_field("cell_glyph", want.cell_glyph, got.cell_glyph);
				end
			end
		end
		words_pending <= predicted_words.size();
	end

endmodule

[dv/tb_scrolling_text_terminal.sv]
// Testbench top for the scrolling text terminal: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_scrolling_text_terminal;
	import stt_pkg::*;

	localparam int COLUMNS    = COLUMNS_DEF;
	localparam int ROWS       = ROWS_DEF;
	localparam int PHASE_LEN  = 325;
	localparam int DRAIN_WAIT = COLUMNS + 24;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	// char_code[7:0], column[13:8], row[18:14], boot_hold[19], zero fill
	logic [S_DATA_W-1:0] s_tdata;
	// operation[1:0]
	logic [W_OP-1:0]     s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	// cursor_col[5:0], cursor_row[10:6], top_row[15:11], cell_glyph[22:16], zero fill
	logic [M_DATA_W-1:0] m_tdata;

	int mismatch_count;
	int words_pending;
	int send_idle_pct;
	int sink_stall_pct;

	scrolling_text_terminal #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	stt_checker #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.mismatch_count (mismatch_count),
		.words_pending  (words_pending)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Receiver back-pressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Offer one word, with random idle cycles ahead of it, and hold until taken
	task automatic send_word(op_t op, logic [W_CODE-1:0] code, logic [W_COL-1:0] col,
			logic [W_ROW-1:0] line, logic hold);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, hold, line, col, code};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Run timeout
	initial begin
		#12ms;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		op_t               op;
		logic [W_CODE-1:0] code;
		logic [W_COL-1:0]  col;
		logic [W_ROW-1:0]  line;
		logic              hold;
		int                pick;

		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = OP_WRITE;
		m_tready       = 1'b0;
		send_idle_pct  = 0;
		sink_stall_pct = 0;
		arst_n         = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: power-on pattern, folding, control codes, wrap, scroll, ranges
		send_word(OP_READ, 8'h00, 6'd0, 5'd0, 1'b0);
		send_word(OP_READ, 8'h00, 6'd1, 5'd0, 1'b0);
		send_word(OP_READ, 8'h00, 6'd39, 5'd23, 1'b0);
		send_word(OP_WRITE, 8'h41, 6'd0, 5'd0, 1'b0);
		send_word(OP_WRITE, 8'h61, 6'd0, 5'd0, 1'b0);
		send_word(OP_WRITE, 8'h7F, 6'd0, 5'd0, 1'b0);
		send_word(OP_WRITE, 8'h80, 6'd0, 5'd0, 1'b0);
		send_word(OP_WRITE, 8'h9F, 6'd0, 5'd0, 1'b0);
		send_word(OP_WRITE, 8'hFF, 6'd0, 5'd0, 1'b0);
		send_word(OP_WRITE, 8'h01, 6'd0, 5'd0, 1'b0);
		send_word(OP_WRITE, 8'h5A, 6'd0, 5'd0, 1'b1);
		send_word(OP_WRITE, CODE_BS, 6'd0, 5'd0, 1'b0);
		send_word(OP_READ, 8'h00, 6'd5, 5'd0, 1'b0);
		send_word(OP_WRITE, CODE_CR, 6'd0, 5'd0, 1'b0);
		send_word(OP_WRITE, CODE_BS, 6'd0, 5'd0, 1'b0);
		send_word(OP_SET, 8'h00, 6'd63, 5'd31, 1'b0);
		send_word(OP_SET, 8'h00, 6'd39, 5'd23, 1'b0);
		send_word(OP_WRITE, CODE_SPACE, 6'd0, 5'd0, 1'b0);
		// backspace from the pending-wrap column
		send_word(OP_WRITE, CODE_BS, 6'd0, 5'd0, 1'b0);
		send_word(OP_WRITE, 8'h5A, 6'd0, 5'd0, 1'b0);
		send_word(OP_WRITE, 8'h59, 6'd0, 5'd0, 1'b0);
		send_word(OP_WRITE, CODE_CR, 6'd0, 5'd0, 1'b0);
		send_word(OP_READ, 8'h00, 6'd40, 5'd0, 1'b0);
		send_word(OP_READ, 8'h00, 6'd0, 5'd24, 1'b0);
		send_word(OP_READ, 8'h00, 6'd63, 5'd31, 1'b0);
		send_word(OP_CLEAR, 8'hFF, 6'd63, 5'd31, 1'b1);
		send_word(OP_READ, 8'h00, 6'd0, 5'd0, 1'b0);

		// Random: mostly text and new lines, with cursor moves, reads and occasional clears
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin send_idle_pct = 46; sink_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  sink_stall_pct = 46; end
				default: begin send_idle_pct = 38; sink_stall_pct = 38; end
			endcase
			for (int n = 0; n < PHASE_LEN; n++) begin
				code = W_CODE'($urandom_range(255));
				col  = W_COL'($urandom_range(63));
				line = W_ROW'($urandom_range(31));
				hold = ($urandom_range(1) != 0);
				pick = $urandom_range(99);
				if (pick < 68) begin
					op   = OP_WRITE;
					hold = ($urandom_range(99) < 6);
					pick = $urandom_range(99);
					if (pick < 62)
						code = W_CODE'($urandom_range(8'h7F, CODE_SPACE));
					else if (pick < 74)
						code = CODE_CR;
					else if (pick < 84)
						code = CODE_BS;
				end else if (pick < 84) begin
					op = OP_READ;
					if ($urandom_range(99) < 85) begin
						col  = W_COL'($urandom_range(COLUMNS - 1));
						line = W_ROW'($urandom_range(ROWS - 1));
					end
				end else if (pick < 98) begin
					op = OP_SET;
					if ($urandom_range(99) < 85) begin
						col  = W_COL'($urandom_range(COLUMNS - 1));
						line = ($urandom_range(1) != 0) ? W_ROW'(ROWS - 1) :
							W_ROW'($urandom_range(ROWS - 1));
					end
				end else begin
					op = OP_CLEAR;
				end
				send_word(op, code, col, line, hold);
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (words_pending != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
